// File: hw/rtl/rcn_pkg.sv
// rcn_pkg: shared types and constants of the channel normalizer.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none

package rcn_pkg;

	localparam int TICK_W     = 16;
	localparam int US_W       = 16;
	localparam int NUM_W      = 23;
	localparam int DEN_W      = 16;
	localparam int CNT_W      = 5;
	localparam int BYTE_W     = 8;
	localparam int IDX_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int DELTA_W    = 10;
	localparam int CENTER_W   = 12;
	localparam int IN_DATA_W  = 80;

	localparam logic [CFG_IDX_W-1:0] REG_ENDPOINT_DELTA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_CENTER   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENDED_FRAME = 2'd2;

	localparam logic [DELTA_W-1:0]  DELTA_RESET  = 10'd200;
	localparam logic [CENTER_W-1:0] CENTER_RESET = 12'd1500;

	localparam logic [BYTE_W-1:0] FRAME_MAGIC  = 8'h87;
	localparam logic [BYTE_W-1:0] STARTUP_FLAG = 8'h10;
	localparam logic [CENTER_W-1:0] SWITCH_HYST = 12'd5;
	localparam logic [US_W-1:0] PULSE_MIN  = 16'd600;
	localparam logic [US_W-1:0] PULSE_MAX  = 16'd2500;
	localparam logic [US_W-1:0] CLAMP_LOW  = 16'd800;
	localparam logic [US_W-1:0] CLAMP_HIGH = 16'd2300;
	localparam logic [6:0] PCT_SCALE = 7'd101;
	localparam logic [6:0] PCT_LIMIT = 7'd100;

	localparam logic [IDX_W-1:0] LAST_SHORT = 3'd3;
	localparam logic [IDX_W-1:0] LAST_LONG  = 3'd7;
	localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(NUM_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CAL,
		ST_PREP,
		ST_DIV,
		ST_STORE,
		ST_SWITCH,
		ST_SEND
	} state_t;

	typedef struct packed {
		logic load;
		logic calib;
		logic prep;
		logic store;
		logic sw_upd;
		logic send_adv;
	} cmd_t;

	typedef struct packed {
		logic stick_valid;
		logic div_busy;
		logic ch_last;
		logic byte_last;
	} status_t;

endpackage

`default_nettype wire

// File: hw/rtl/rc_channel_normalizer.sv
// rc_channel_normalizer: top level, joins the sequencer and the datapath.
// Depends on rcn_pkg, rcn_ctrl, rcn_dp (and rcn_div below it).
//
// channel  group                        width  contents
// input    s_tvalid/s_tready            80+1   tick of receiver data
// output   m_tvalid/m_tready            8+1    frame bytes, tlast on the final one
// config   cfg_we/cfg_index/cfg_data    2+12   endpoint_delta, pulse_center,
//                                              extended_frame
//
// One tick at a time: accept, calibrate, then per stick a setup, the divider
// state (23 quotient steps and a check that it is done) and a store, then a
// switch update, then 4 or 8 bytes; the shared divider sets the pace. An
// invalid tick skips the arithmetic.
// s_tready is high only while idle; output stalls hold the current byte.
// arst_n clears state and calibration and returns the config registers to their defaults.
`default_nettype none

module rc_channel_normalizer (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// ch1_ticks, ch2_ticks, ch3_ticks, raw_word_a, raw_word_b
	input  wire logic [rcn_pkg::IN_DATA_W-1:0]   s_tdata,
	// stick_valid
	input  wire logic                            s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// frame_byte
	output logic [rcn_pkg::BYTE_W-1:0]           m_tdata,
	output logic                                 m_tlast,
	input  wire logic                            cfg_we,
	input  wire logic [rcn_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rcn_pkg::CFG_DATA_W-1:0]  cfg_data
);

	rcn_pkg::cmd_t    cmd;
	rcn_pkg::status_t status;

	rcn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	rcn_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tuser),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.out_byte  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

`default_nettype wire

// File: hw/rtl/rcn_div.sv
// rcn_div: restoring divider, one quotient bit per cycle.
// Depends on rcn_pkg for widths.
`default_nettype none

module rcn_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [rcn_pkg::NUM_W-1:0]  num,
	input  wire logic [rcn_pkg::DEN_W-1:0]  den,
	output logic                            busy,
	output logic [rcn_pkg::NUM_W-1:0]       quo
);

	logic                       busy_q;
	logic [rcn_pkg::CNT_W-1:0]  cnt_q;
	logic [rcn_pkg::DEN_W-1:0]  rem_q;
	logic [rcn_pkg::DEN_W-1:0]  den_q;
	logic [rcn_pkg::NUM_W-1:0]  quo_q;
	logic [rcn_pkg::DEN_W:0]    rem_sh;
	logic                       fits;
	logic [rcn_pkg::DEN_W-1:0]  rem_nx;

	always_comb begin
		rem_sh = {rem_q, quo_q[rcn_pkg::NUM_W-1]};
		fits   = rem_sh >= {1'b0, den_q};
		rem_nx = fits ? rcn_pkg::DEN_W'(rem_sh - {1'b0, den_q})
		              : rem_sh[rcn_pkg::DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == rcn_pkg::DIV_LAST) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[rcn_pkg::NUM_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

// File: hw/rtl/rcn_ctrl.sv
// rcn_ctrl: sequencer of the channel normalizer.
// Depends on rcn_pkg for state, command and status types.
`default_nettype none

module rcn_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	input  wire rcn_pkg::status_t status,
	output rcn_pkg::cmd_t         cmd
);

	rcn_pkg::state_t state_q;
	rcn_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcn_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			rcn_pkg::ST_IDLE: begin
				if (s_tvalid) state_nx = rcn_pkg::ST_CAL;
			end
			rcn_pkg::ST_CAL: begin
				state_nx = status.stick_valid ? rcn_pkg::ST_PREP : rcn_pkg::ST_SEND;
			end
			rcn_pkg::ST_PREP: begin
				state_nx = rcn_pkg::ST_DIV;
			end
			rcn_pkg::ST_DIV: begin
				if (!status.div_busy) state_nx = rcn_pkg::ST_STORE;
			end
			rcn_pkg::ST_STORE: begin
				state_nx = status.ch_last ? rcn_pkg::ST_SWITCH : rcn_pkg::ST_PREP;
			end
			rcn_pkg::ST_SWITCH: begin
				state_nx = rcn_pkg::ST_SEND;
			end
			rcn_pkg::ST_SEND: begin
				if (m_tready && status.byte_last) state_nx = rcn_pkg::ST_IDLE;
			end
			default: begin
				state_nx = rcn_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		cmd      = '0;
		case (state_q)
			rcn_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			rcn_pkg::ST_CAL: begin
				cmd.calib = status.stick_valid;
			end
			rcn_pkg::ST_PREP: begin
				cmd.prep = 1'b1;
			end
			rcn_pkg::ST_STORE: begin
				cmd.store = 1'b1;
			end
			rcn_pkg::ST_SWITCH: begin
				cmd.sw_upd = 1'b1;
			end
			rcn_pkg::ST_SEND: begin
				m_tvalid     = 1'b1;
				cmd.send_adv = m_tready;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hw/rtl/rcn_dp.sv
// rcn_dp: datapath of the channel normalizer: scaling, calibration, end
// points, percentage division, switch hysteresis and frame byte select.
// Depends on rcn_pkg and rcn_div.
`default_nettype none

module rcn_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [rcn_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rcn_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	input  wire logic [rcn_pkg::IN_DATA_W-1:0]   in_data,
	input  wire rcn_pkg::cmd_t                   cmd,
	output rcn_pkg::status_t                     status,
	output logic [rcn_pkg::BYTE_W-1:0]           out_byte,
	output logic                                 out_last
);

	logic [rcn_pkg::DELTA_W-1:0]  delta_q;
	logic [rcn_pkg::CENTER_W-1:0] center_q;
	logic                         ext_cfg_q;

	logic                         valid_q;
	logic                         ext_q;
	logic [rcn_pkg::US_W-1:0]     us_q [2];
	logic [rcn_pkg::US_W-1:0]     sw_us_q;
	logic [rcn_pkg::TICK_W-1:0]   raw_a_q;
	logic [rcn_pkg::TICK_W-1:0]   raw_b_q;

	logic                         cal_q;
	logic [rcn_pkg::US_W-1:0]     centre_q [2];
	logic [rcn_pkg::US_W-1:0]     low_q [2];
	logic [rcn_pkg::US_W-1:0]     high_q [2];
	logic                         sw_on_q;

	logic                         ch_q;
	logic                         zero_q;
	logic                         neg_q;
	logic [rcn_pkg::BYTE_W-1:0]   pct_q [2];
	logic [rcn_pkg::BYTE_W-1:0]   flags_q;
	logic [rcn_pkg::IDX_W-1:0]    idx_q;

	logic [rcn_pkg::TICK_W-1:0]   tick [3];
	logic [rcn_pkg::US_W-1:0]     scaled [3];
	logic [rcn_pkg::US_W-1:0]     us_raw, uc, cen, lo, hi, lo_nx, hi_nx, diff;
	logic                         in_range, below, above, zero;
	logic [rcn_pkg::NUM_W-1:0]    num;
	logic [rcn_pkg::DEN_W-1:0]    den;
	logic                         div_busy;
	logic [rcn_pkg::NUM_W-1:0]    quo;
	logic [6:0]                   mag;
	logic [rcn_pkg::BYTE_W-1:0]   pct;
	logic [rcn_pkg::US_W-1:0]     on_lvl, off_lvl;
	logic                         sw_nx;
	logic [rcn_pkg::BYTE_W-1:0]   frame [8];

	rcn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.prep),
		.num    (num),
		.den    (den),
		.busy   (div_busy),
		.quo    (quo)
	);

	// scale 750 ns ticks to microseconds: t * 3 / 4
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			tick[k]   = in_data[k*rcn_pkg::TICK_W +: rcn_pkg::TICK_W];
			scaled[k] = rcn_pkg::US_W'(({2'b00, tick[k]} + {1'b0, tick[k], 1'b0}) >> 2);
		end
	end

	always_comb begin
		us_raw   = us_q[ch_q];
		cen      = centre_q[ch_q];
		lo       = low_q[ch_q];
		hi       = high_q[ch_q];
		in_range = (us_raw >= rcn_pkg::PULSE_MIN) && (us_raw <= rcn_pkg::PULSE_MAX);
		if (us_raw < rcn_pkg::CLAMP_LOW) begin
			uc = rcn_pkg::CLAMP_LOW;
		end else if (us_raw > rcn_pkg::CLAMP_HIGH) begin
			uc = rcn_pkg::CLAMP_HIGH;
		end else begin
			uc = us_raw;
		end
		below = uc < cen;
		above = uc > cen;
		zero  = !in_range || (uc == cen);
		lo_nx = (in_range && below && (uc < lo)) ? uc : lo;
		hi_nx = (in_range && above && (uc > hi)) ? uc : hi;
		diff  = below ? cen - uc : uc - cen;
		num   = rcn_pkg::NUM_W'(diff) * rcn_pkg::NUM_W'(rcn_pkg::PCT_SCALE);
		den   = below ? cen - lo_nx : hi_nx - cen;
	end

	always_comb begin
		mag = (quo > rcn_pkg::NUM_W'(rcn_pkg::PCT_LIMIT)) ? rcn_pkg::PCT_LIMIT : quo[6:0];
		if (zero_q) begin
			pct = '0;
		end else if (neg_q) begin
			pct = rcn_pkg::BYTE_W'(-{1'b0, mag});
		end else begin
			pct = {1'b0, mag};
		end
	end

	always_comb begin
		on_lvl  = rcn_pkg::US_W'(center_q) + rcn_pkg::US_W'(rcn_pkg::SWITCH_HYST);
		off_lvl = rcn_pkg::US_W'(center_q) - rcn_pkg::US_W'(rcn_pkg::SWITCH_HYST);
		if (sw_on_q) begin
			sw_nx = !((center_q >= rcn_pkg::SWITCH_HYST) && (sw_us_q < off_lvl));
		end else begin
			sw_nx = sw_us_q > on_lvl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_q   <= rcn_pkg::DELTA_RESET;
			center_q  <= rcn_pkg::CENTER_RESET;
			ext_cfg_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				rcn_pkg::REG_ENDPOINT_DELTA: delta_q   <= cfg_data[rcn_pkg::DELTA_W-1:0];
				rcn_pkg::REG_PULSE_CENTER:   center_q  <= cfg_data;
				rcn_pkg::REG_EXTENDED_FRAME: ext_cfg_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q   <= 1'b0;
			sw_on_q <= 1'b0;
			ch_q    <= 1'b0;
			idx_q   <= '0;
			for (int k = 0; k < 2; k++) begin
				centre_q[k] <= '0;
				low_q[k]    <= '0;
				high_q[k]   <= '0;
			end
		end else begin
			if (cmd.load) begin
				ch_q  <= 1'b0;
				idx_q <= '0;
			end
			if (cmd.calib && !cal_q) begin
				cal_q <= 1'b1;
				for (int k = 0; k < 2; k++) begin
					centre_q[k] <= us_q[k];
					low_q[k]    <= (us_q[k] > rcn_pkg::US_W'(delta_q))
					               ? us_q[k] - rcn_pkg::US_W'(delta_q) : '0;
					high_q[k]   <= us_q[k] + rcn_pkg::US_W'(delta_q);
				end
			end
			if (cmd.prep) begin
				low_q[ch_q]  <= lo_nx;
				high_q[ch_q] <= hi_nx;
			end
			if (cmd.store) begin
				ch_q <= ~ch_q;
			end
			if (cmd.sw_upd) begin
				sw_on_q <= sw_nx;
			end
			if (cmd.send_adv) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			valid_q  <= in_valid;
			ext_q    <= ext_cfg_q;
			us_q[0]  <= scaled[0];
			us_q[1]  <= scaled[1];
			sw_us_q  <= scaled[2];
			raw_a_q  <= in_data[3*rcn_pkg::TICK_W +: rcn_pkg::TICK_W];
			raw_b_q  <= in_data[4*rcn_pkg::TICK_W +: rcn_pkg::TICK_W];
			pct_q[0] <= '0;
			pct_q[1] <= '0;
			flags_q  <= in_valid ? '0 : rcn_pkg::STARTUP_FLAG;
		end
		if (cmd.prep) begin
			zero_q <= zero;
			neg_q  <= below;
		end
		if (cmd.store) begin
			pct_q[ch_q] <= pct;
		end
		if (cmd.sw_upd) begin
			flags_q <= {7'b0, sw_nx};
		end
	end

	always_comb begin
		frame[0] = rcn_pkg::FRAME_MAGIC;
		frame[1] = pct_q[0];
		frame[2] = pct_q[1];
		frame[3] = flags_q;
		frame[4] = {1'b0, raw_a_q[11:5]};
		frame[5] = {1'b0, raw_a_q[4:0], raw_b_q[15:14]};
		frame[6] = {1'b0, raw_b_q[13:7]};
		frame[7] = {1'b0, raw_b_q[6:0]};
	end

	assign out_byte = frame[idx_q];
	assign out_last = idx_q == (ext_q ? rcn_pkg::LAST_LONG : rcn_pkg::LAST_SHORT);

	always_comb begin
		status.stick_valid = valid_q;
		status.div_busy    = div_busy;
		status.ch_last     = ch_q;
		status.byte_last   = out_last;
	end

endmodule

`default_nettype wire
